[rtl/pexe_pkg.sv]
// Shared types and constants for the parenthesized expression evaluator.
package pexe_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int KIND_W          = 3;
  localparam int TVAL_W          = 31;
  localparam int VAL_W           = 32;
  localparam int NUM_BANKS       = 4;
  localparam int BANK_ROW_W_DEF  = 3;

  typedef enum logic [KIND_W-1:0] {
    TK_NUM   = 3'd0,
    TK_OPEN  = 3'd1,
    TK_CLOSE = 3'd2,
    TK_ADD   = 3'd3,
    TK_SUB   = 3'd4,
    TK_MUL   = 3'd5
  } tok_kind_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  value;
  } entry_t;

endpackage

[rtl/paren_expression_evaluator_unit.sv]
// Output: a result word appears on out_* in the cycle after the last token is accepted.
// Throughput: one token per cycle while in_stall is low; the stack is split into four banks whose
//   registered reads prefetch the top four entries, and each reduction does one
//   32x32 multiply (low half) or add/subtract on two window entries.
// Reset: synchronous, active low; clears count, flags and output valid. Stack
//   memory is not cleared and needs no clearing pass.
module paren_expression_evaluator_unit #(
  parameter int STACK_DEPTH = pexe_pkg::STACK_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pexe_pkg::KIND_W-1:0]         in_token_kind,
  input  logic [pexe_pkg::TVAL_W-1:0]         in_token_value,
  input  logic                                in_last_token,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pexe_pkg::VAL_W-1:0]   out_result_value,
  output logic                                out_syntax_error
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int ROW_W = $clog2((STACK_DEPTH + 3) / 4);
  localparam int IW    = ROW_W + 2;

  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      err_r, err_nxt;
  logic                      start_r, start_nxt;
  logic                      red_r, red_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [pexe_pkg::VAL_W-1:0] res_r, res_nxt;
  logic                      serr_r, serr_nxt;

  logic                      acc;
  logic                      load_out;
  logic                      good;
  logic                      wr_en;
  logic [CNT_W-1:0]          wr_idx;
  logic [CNT_W-1:0]          base;
  pexe_pkg::entry_t          wr_ent;
  pexe_pkg::entry_t          rd_ent [pexe_pkg::NUM_BANKS];
  pexe_pkg::entry_t          win [4];
  logic [1:0]                win_sel [4];
  pexe_pkg::tok_kind_t       op_kind;
  logic                      red_ok;
  logic [pexe_pkg::VAL_W-1:0] red_val;
  logic [2*pexe_pkg::VAL_W-1:0] prod;
  logic [pexe_pkg::VAL_W-1:0] push_val;
  logic [CNT_W-1:0]          top_n;

  assign in_stall         = out_valid_r & out_stall;
  assign acc              = in_valid & ~in_stall;
  assign out_valid        = out_valid_r;
  assign out_result_value = $signed(res_r);
  assign out_syntax_error = serr_r;

  // window slot j holds stack entry count-4+j
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      win_sel[j] = cnt_r[1:0] + 2'(j);
      win[j]     = rd_ent[win_sel[j]];
    end
  end

  assign base    = cnt_r - CNT_W'(4);
  assign op_kind = pexe_pkg::tok_kind_t'(win[2].kind);
  assign prod    = win[1].value * win[3].value;

  assign red_ok = (cnt_r >= CNT_W'(4)) &&
                  (win[0].kind == pexe_pkg::TK_OPEN) &&
                  (win[1].kind == pexe_pkg::TK_NUM) &&
                  (win[3].kind == pexe_pkg::TK_NUM) &&
                  ((op_kind == pexe_pkg::TK_ADD) || (op_kind == pexe_pkg::TK_SUB) ||
                   (op_kind == pexe_pkg::TK_MUL));

  always_comb begin
    case (op_kind)
      pexe_pkg::TK_ADD: red_val = win[1].value + win[3].value;
      pexe_pkg::TK_SUB: red_val = win[1].value - win[3].value;
      default:          red_val = prod[pexe_pkg::VAL_W-1:0];
    endcase
  end

  assign push_val = (in_token_kind == pexe_pkg::TK_NUM) ?
                    {1'b0, in_token_value} : '0;

  always_comb begin
    cnt_nxt     = cnt_r;
    err_nxt     = err_r;
    start_nxt   = start_r;
    red_nxt     = red_r;
    wr_en       = 1'b0;
    wr_idx      = cnt_r;
    wr_ent.kind  = in_token_kind;
    wr_ent.value = push_val;
    load_out    = 1'b0;
    good        = 1'b0;
    res_nxt     = '0;
    serr_nxt    = 1'b0;
    if (acc) begin
      if (start_r && in_last_token) begin
        // lone token: only a number is a valid expression
        load_out  = 1'b1;
        good      = (in_token_kind == pexe_pkg::TK_NUM);
        serr_nxt  = ~good;
        res_nxt   = good ? {1'b0, in_token_value} : '0;
        cnt_nxt   = '0;
        err_nxt   = 1'b0;
        start_nxt = 1'b1;
        red_nxt   = 1'b0;
      end else begin
        start_nxt = 1'b0;
        case (in_token_kind)
          pexe_pkg::TK_CLOSE: begin
            if (red_ok) begin
              wr_en        = 1'b1;
              wr_idx       = base;
              wr_ent.kind  = pexe_pkg::TK_NUM;
              wr_ent.value = red_val;
              cnt_nxt      = base + CNT_W'(1);
              red_nxt      = 1'b1;
            end else begin
              err_nxt = 1'b1;
            end
          end
          pexe_pkg::TK_NUM, pexe_pkg::TK_OPEN, pexe_pkg::TK_ADD,
          pexe_pkg::TK_SUB, pexe_pkg::TK_MUL: begin
            if (cnt_r < CNT_W'(STACK_DEPTH)) begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r + CNT_W'(1);
            end else begin
              err_nxt = 1'b1;
            end
          end
          default: err_nxt = 1'b1;
        endcase
        if (in_last_token) begin
          // a good finish implies this token reduced into the bottom entry
          load_out  = 1'b1;
          good      = ~err_nxt & red_nxt & (cnt_nxt == CNT_W'(1));
          serr_nxt  = ~good;
          res_nxt   = good ? red_val : '0;
          cnt_nxt   = '0;
          err_nxt   = 1'b0;
          start_nxt = 1'b1;
          red_nxt   = 1'b0;
        end
      end
    end
  end

  assign out_valid_nxt = load_out | (out_valid_r & out_stall);
  assign top_n         = cnt_nxt - CNT_W'(1);

  for (genvar k = 0; k < pexe_pkg::NUM_BANKS; k++) begin : g_bank
    logic [1:0]       off;
    logic [CNT_W-1:0] rd_idx;

    // prefetch the entry of entries count'-4..count'-1 that lives in this bank
    assign off    = top_n[1:0] - 2'(k);
    assign rd_idx = top_n - CNT_W'(off);

    pexe_stack_bank #(
      .ROW_W (ROW_W)
    ) u_bank (
      .clk      (clk),
      .wr_en    (wr_en && (wr_idx[1:0] == 2'(k))),
      .wr_row   (wr_idx[IW-1:2]),
      .wr_ent   (wr_ent),
      .rd_row   (rd_idx[IW-1:2]),
      .rd_ent_r (rd_ent[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      err_r       <= 1'b0;
      start_r     <= 1'b1;
      red_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      start_r     <= start_nxt;
      red_r       <= red_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_r  <= res_nxt;
      serr_r <= serr_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_last_token |=> (cnt_r == '0) && start_r && !err_r && !red_r && out_valid_r)
    else $error("expression state not cleared after last word");

  a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> (cnt_r == '0) && !err_r && !red_r)
    else $error("start state with leftover stack");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && serr_r |-> (res_r == '0))
    else $error("error result carries nonzero value");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r && !(acc && in_last_token) |=> err_r)
    else $error("error flag dropped mid-expression");

endmodule

[rtl/pexe_stack_bank.sv]
// One bank of the token stack: one write port, one registered read port with bypass.
module pexe_stack_bank #(
  parameter int ROW_W = pexe_pkg::BANK_ROW_W_DEF
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [ROW_W-1:0] wr_row,
  input  pexe_pkg::entry_t wr_ent,
  input  logic [ROW_W-1:0] rd_row,
  output pexe_pkg::entry_t rd_ent_r
);

  localparam int ROWS = 2 ** ROW_W;

  pexe_pkg::entry_t mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_ent;
    end
  end

  // forward a same-cycle write so the window sees the new top
  always_ff @(posedge clk) begin
    if (wr_en && (wr_row == rd_row)) begin
      rd_ent_r <= wr_ent;
    end else begin
      rd_ent_r <= mem[rd_row];
    end
  end

endmodule
